@@ src/psfp_pkg.sv @@
// ----------------------------------------------------------------------------
// psfp_pkg
// shared constants and controller/datapath handshake types for the
// particle sensor frame parser
// ----------------------------------------------------------------------------
package psfp_pkg;

  localparam int unsigned FRAME_WORDS_DEF = 15;
  localparam int unsigned COUNT_W         = 6;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned WORD_W          = 16;
  localparam int unsigned INDEX_W         = 4;
  localparam logic [7:0]  START_BYTE      = 8'h42;

  // commands from the controller to the datapath
  typedef struct packed {
    logic take_byte;
    logic emit_step;
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic frame_end;
    logic emit_last;
  } dp_stat_t;

endpackage

@@ src/particle_sensor_frame_parser.sv @@
// ----------------------------------------------------------------------------
// particle_sensor_frame_parser
// parses the byte stream of a particle sensor serial link into word runs
// ----------------------------------------------------------------------------
// usage:
//   in_*  : one received byte per request. bytes are dropped until a 0x42
//           start byte opens a frame of 2 + 2*FRAME_WORDS bytes.
//   out_* : at frame end the block emits FRAME_WORDS requests, one word
//           each: word index, big-endian value, frame_ok (byte sum of all
//           but the last two bytes equals the checksum word) and last.
//   timing: bytes are taken while receiving. the first word is offered
//           the cycle after the frame's final byte, then one word per
//           cycle while out_ready is high.
//   throughput: set by the single controller loop: input is held off
//           (in_ready low) for the whole word run, reads of the word
//           register file are one per cycle.
//   stalls: while out_ready is low the current word holds and no byte is
//           taken.
//   reset: rst_n low (synchronous) returns to hunting for a start byte with
//           nothing pending.
// ----------------------------------------------------------------------------
module particle_sensor_frame_parser #(
  parameter int unsigned FRAME_WORDS = psfp_pkg::FRAME_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [psfp_pkg::BYTE_W-1:0]   in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [psfp_pkg::INDEX_W-1:0]  out_word_index,
  output logic [psfp_pkg::WORD_W-1:0]   out_word_value,
  output logic                          out_frame_ok,
  output logic                          out_last
);

  psfp_pkg::ctrl_cmd_t cmd;
  psfp_pkg::dp_stat_t  stat;

  psfp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  psfp_datapath #(
    .FRAME_WORDS (FRAME_WORDS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .rx_byte    (in_rx_byte),
    .word_index (out_word_index),
    .word_value (out_word_value),
    .frame_ok   (out_frame_ok),
    .last       (out_last)
  );

  // input and output never open together
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("in_ready and out_valid high together");

  // end of a run hands back to receiving
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> (in_ready && !out_valid))
    else $error("no return to receiving after last word");

  // words of a run come in order without gaps
  a_run_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=>
      (out_valid && (out_word_index == 4'($past(out_word_index) + 4'd1))))
    else $error("word run out of sequence");

  // the checksum flag is one value for the whole run
  a_ok_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(out_valid)) |-> $stable(out_frame_ok))
    else $error("frame_ok changed within a run");

endmodule

@@ src/psfp_ctrl.sv @@
// ----------------------------------------------------------------------------
// psfp_ctrl
// controller: takes bytes while receiving, then drives the word run at
// frame end until its last word is taken
// ----------------------------------------------------------------------------
module psfp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  psfp_pkg::dp_stat_t  stat,
  output psfp_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_RECV = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd.take_byte = 1'b0;
    cmd.emit_step = 1'b0;
    state_nxt     = state_r;
    unique case (state_r)
      ST_RECV: begin
        in_ready      = 1'b1;
        cmd.take_byte = in_valid;
        if (in_valid && stat.frame_end) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid     = 1'b1;
        cmd.emit_step = out_ready;
        if (out_ready && stat.emit_last) begin
          state_nxt = ST_RECV;
        end
      end
      default: begin
        state_nxt = ST_RECV;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RECV;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ src/psfp_datapath.sv @@
// ----------------------------------------------------------------------------
// psfp_datapath
// byte position counter, wrapping byte sum, word assembly into a small
// register file and the read-out index for the word run
// ----------------------------------------------------------------------------
module psfp_datapath #(
  parameter int unsigned FRAME_WORDS = psfp_pkg::FRAME_WORDS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  psfp_pkg::ctrl_cmd_t                 cmd,
  output psfp_pkg::dp_stat_t                  stat,
  input  logic [psfp_pkg::BYTE_W-1:0]         rx_byte,
  output logic [psfp_pkg::INDEX_W-1:0]        word_index,
  output logic [psfp_pkg::WORD_W-1:0]         word_value,
  output logic                                frame_ok,
  output logic                                last
);

  localparam int unsigned FRAME_BYTES = 2 + 2 * FRAME_WORDS;
  localparam int unsigned SUM_BYTES   = 2 * FRAME_WORDS;
  localparam int unsigned IDX_W       = $clog2(FRAME_WORDS);
  localparam int unsigned CW          = psfp_pkg::COUNT_W;

  logic [CW-1:0]                  pos_r;
  logic [psfp_pkg::WORD_W-1:0]    sum_r;
  logic [psfp_pkg::BYTE_W-1:0]    hold_r;
  logic                           ok_r;
  logic [IDX_W-1:0]               idx_r;
  logic [psfp_pkg::WORD_W-1:0]    words_r [FRAME_WORDS];
  logic [psfp_pkg::WORD_W-1:0]    rd_word_r;

  logic [CW-1:0]                  pos_nxt;
  logic [psfp_pkg::WORD_W-1:0]    sum_nxt;
  logic [psfp_pkg::WORD_W-1:0]    word_asm;
  logic [CW-1:0]                  pos_off;
  logic [IDX_W-1:0]               wr_addr;
  logic                           wr_en;
  logic [IDX_W-1:0]               rd_addr;
  logic                           rd_en;
  logic [IDX_W+psfp_pkg::INDEX_W-1:0] idx_ext;

  assign word_asm = {hold_r, rx_byte};
  assign pos_off  = pos_r - CW'(2);
  assign wr_addr  = pos_off[IDX_W:1];
  assign wr_en    = cmd.take_byte && (pos_r >= CW'(2)) && pos_r[0];

  // word 0 is fetched as the frame closes, each later word as the one before is taken
  assign rd_en    = (cmd.take_byte && stat.frame_end) || (cmd.emit_step && !stat.emit_last);
  assign rd_addr  = cmd.emit_step ? (idx_r + IDX_W'(1)) : '0;

  assign stat.frame_end = (pos_r == CW'(FRAME_BYTES - 1));
  assign stat.emit_last = (idx_r == IDX_W'(FRAME_WORDS - 1));

  always_comb begin
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    if (pos_r == '0) begin
      // hunting: only the start byte opens a frame
      if (rx_byte == psfp_pkg::START_BYTE) begin
        pos_nxt = CW'(1);
        sum_nxt = {{(psfp_pkg::WORD_W - psfp_pkg::BYTE_W){1'b0}}, rx_byte};
      end
    end else begin
      if (pos_r < CW'(SUM_BYTES)) begin
        sum_nxt = sum_r + {{(psfp_pkg::WORD_W - psfp_pkg::BYTE_W){1'b0}}, rx_byte};
      end
      if (stat.frame_end) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      sum_r  <= '0;
      hold_r <= '0;
      ok_r   <= 1'b0;
      idx_r  <= '0;
    end else begin
      if (cmd.take_byte) begin
        pos_r <= pos_nxt;
        sum_r <= sum_nxt;
        if ((pos_r >= CW'(2)) && !pos_r[0]) begin
          hold_r <= rx_byte;
        end
        if (stat.frame_end) begin
          // the checksum word is the one being completed now
          ok_r  <= (sum_r == word_asm);
          idx_r <= '0;
        end
      end
      if (cmd.emit_step) begin
        idx_r <= stat.emit_last ? '0 : idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      words_r[wr_addr] <= word_asm;
    end
    if (rd_en) begin
      rd_word_r <= words_r[rd_addr];
    end
  end

  assign idx_ext    = {{psfp_pkg::INDEX_W{1'b0}}, idx_r};
  assign word_index = idx_ext[psfp_pkg::INDEX_W-1:0];
  assign word_value = rd_word_r;
  assign frame_ok   = ok_r;
  assign last       = stat.emit_last;

endmodule
